// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/kat_pkg.sv =====
// ----------------------------------------------------------------------------
// kat_pkg
// Types and constants shared by the keyframe animation timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kat_pkg;

   // Item kinds carried on req_tuser
   typedef enum logic [1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_WRITE   = 2'd1,
      FUNC_RESTART = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FRAME = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_SPAN  = 1'b1;

   // Field widths
   localparam int FUNC_W      = 2;
   localparam int IN_TIME_W   = 16;
   localparam int FRAME_W     = 6;
   localparam int START_W     = 10;
   localparam int NUMBER_W    = 11;
   localparam int FRAC_BITS   = 16;
   localparam int FRACTION_W  = FRAC_BITS + 1;
   localparam int REL_FRAMES  = 64;

   // Packed stream widths
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_PAD_W   = RSP_DATA_W - NUMBER_W - FRACTION_W;

   // Divider handshake towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/kat_ram.sv =====
// ----------------------------------------------------------------------------
// kat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/kat_div.sv =====
// ----------------------------------------------------------------------------
// kat_div
// Restoring divider: (dividend << FRAC_BITS) / divisor, one quotient bit a
// cycle. The dividend never exceeds the divisor, so the integer bit is 0 or 1.
// ----------------------------------------------------------------------------
`default_nettype none

module kat_div #(
   parameter int TIME_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [TIME_BITS:0]                 dividend,
   input  wire logic [TIME_BITS-1:0]               divisor,
   output kat_pkg::div_status_type                 status,
   output logic      [kat_pkg::FRACTION_W-1:0]     quotient
);

   localparam int QW = kat_pkg::FRACTION_W;
   localparam int CW = $clog2(kat_pkg::FRAC_BITS + 1);

   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] dsr_ff, dsr_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic                 first_ge;
   logic [TIME_BITS:0]   trial;
   logic                 trial_ge;

   always_comb begin
      first_ge = dividend >= {1'b0, divisor};
      trial    = {rem_ff, 1'b0};
      trial_ge = trial >= {1'b0, dsr_ff};

      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = TIME_BITS'(dividend - (first_ge ? {1'b0, divisor} : '0));
         dsr_in  = divisor;
         quo_in  = QW'(first_ge);
         cnt_in  = CW'(kat_pkg::FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = TIME_BITS'(trial_ge ? trial - {1'b0, dsr_ff} : trial);
         quo_in = {quo_ff[QW-2:0], trial_ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/keyframe_animation_timer.sv =====
// ----------------------------------------------------------------------------
// keyframe_animation_timer
// Looping keyframe animation timer with a per-frame duration table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: req_tuser selects tick, duration
//   write, restart or no operation; req_tdata holds the operands.
//   rsp_* returns exactly one result per item: the absolute frame number and
//   the blend fraction in unsigned Q1.16.
//   csr_* writes start_frame (index 0) and frame_span (index 1); it is always
//   ready and should only be used while no item is in flight.
// Sequencing:
//   One item at a time. Write, restart and no-operation items pass from idle
//   to the emit state. A tick passes through look-up, divide and emit; each
//   frame skipped is one read-modify step on the duration RAM, whose read
//   port is registered, and the blend fraction comes from a bit-serial
//   divider.
// Reset: frame, timer and fraction clear; the duration table is not cleared
//   and must be written before it is used.
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile, and its own result is held back until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_animation_timer #(
   parameter int MAX_FRAMES = 64,
   parameter int TIME_BITS  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request: [15:0] elapsed_ticks, [21:16] table_index,
   //          [37:22] table_duration, [39:38] zero
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [kat_pkg::REQ_DATA_W-1:0]       req_tdata,
   // request kind: [1:0] func
   input  wire logic [kat_pkg::FUNC_W-1:0]           req_tuser,
   // result: [10:0] frame_number, [27:11] blend_fraction, [31:28] zero
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [kat_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // configuration write
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [kat_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [kat_pkg::START_W-1:0]          csr_data
);

   localparam int AW    = $clog2(MAX_FRAMES);
   localparam int ACC_W = TIME_BITS + 1;
   localparam int FW    = kat_pkg::FRAME_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [FW-1:0]                     frame_ff, frame_in;
   logic [ACC_W-1:0]                  acc_ff, acc_in;
   logic [kat_pkg::FRACTION_W-1:0]    frac_ff, frac_in;
   logic [kat_pkg::START_W-1:0]       start_frame_ff;
   logic [FW-1:0]                     frame_span_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [kat_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // Relative frame (and table index) to RAM slot, modulo MAX_FRAMES
   logic [AW-1:0] frame_slot [kat_pkg::REL_FRAMES];

   for (genvar v = 0; v < kat_pkg::REL_FRAMES; v++) begin : g_slot
      assign frame_slot[v] = AW'(v % MAX_FRAMES);
   end

   logic                              req_accept;
   kat_pkg::func_type                 func;
   logic [kat_pkg::IN_TIME_W-1:0]     elapsed_ticks;
   logic [FW-1:0]                     table_index;
   logic [kat_pkg::IN_TIME_W-1:0]     table_duration;

   logic                              ram_wr_en;
   logic [AW-1:0]                     ram_rd_addr;
   logic [TIME_BITS-1:0]              ram_rd_data;
   logic [TIME_BITS-1:0]              dur;
   logic [FW-1:0]                     next_frame;
   logic                              step;
   logic                              div_start;
   kat_pkg::div_status_type           div_status;
   logic [kat_pkg::FRACTION_W-1:0]    div_quotient;

   assign req_tready     = (state_ff == ST_IDLE);
   assign req_accept     = req_tvalid && req_tready;
   assign func           = kat_pkg::func_type'(req_tuser);
   assign elapsed_ticks  = req_tdata[15:0];
   assign table_index    = req_tdata[21:16];
   assign table_duration = req_tdata[37:22];

   assign csr_ready = 1'b1;

   // A zero duration counts as one tick
   assign dur        = (ram_rd_data == '0) ? TIME_BITS'(1) : ram_rd_data;
   assign next_frame = (frame_ff >= frame_span_ff) ? '0 : frame_ff + FW'(1);

   // Writes only happen in idle and read data is only used during a tick, so a
   // tick never sees an entry that is being written in the same cycle.
   assign ram_wr_en   = req_accept && (func == kat_pkg::FUNC_WRITE);
   assign ram_rd_addr = frame_slot[step ? next_frame : frame_ff];

   kat_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_FRAMES)
   ) u_kat_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (frame_slot[table_index]),
      .wr_data (TIME_BITS'(table_duration)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   kat_div #(
      .TIME_BITS (TIME_BITS)
   ) u_kat_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (dur),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      acc_in       = acc_ff;
      frac_in      = frac_ff;
      step         = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EMIT;
               case (func)
                  kat_pkg::FUNC_TICK: begin
                     acc_in   = acc_ff + ACC_W'(TIME_BITS'(elapsed_ticks));
                     state_in = ST_LOOK;
                  end
                  kat_pkg::FUNC_RESTART: begin
                     frame_in = '0;
                     acc_in   = '0;
                     frac_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOK: begin
            // Skip whole frames while the timer runs past the current one
            if (acc_ff > {1'b0, dur}) begin
               step     = 1'b1;
               acc_in   = acc_ff - {1'b0, dur};
               frame_in = next_frame;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               frac_in  = div_quotient;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{kat_pkg::RSP_PAD_W{1'b0}}, frac_ff,
                               kat_pkg::NUMBER_W'(start_frame_ff)
                               + kat_pkg::NUMBER_W'(frame_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_ff       <= '0;
         acc_ff         <= '0;
         frac_ff        <= '0;
         start_frame_ff <= '0;
         frame_span_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         acc_ff       <= acc_in;
         frac_ff      <= frac_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               kat_pkg::CSR_START_FRAME: start_frame_ff <= csr_data;
               kat_pkg::CSR_FRAME_SPAN:  frame_span_ff  <= FW'(csr_data);
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/kat_checker.sv =====
// ----------------------------------------------------------------------------
// kat_checker
// Port-level checks on the keyframe animation timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kat_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [kat_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // Hold a stalled result
   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Blend fraction never exceeds 1.0
   `ASSERT_CLK(a_frac_range, rsp_tvalid |-> rsp_tdata[27:11] <= 17'h10000, "blend fraction above one")

   // One item in flight: the request side closes after each transfer
   `ASSERT_CLK(a_one_item, req_tvalid && req_tready |=> !req_tready, "second item accepted while busy")

   // No result straight after reset
   `ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind keyframe_animation_timer kat_checker u_kat_checker (.*);

`default_nettype wire

// ===== sim/kat_frame_checker.sv =====
// ----------------------------------------------------------------------------
// kat_frame_checker
// Watches the request, result and register channels of the keyframe animation
// timer, keeps its own copy of the duration table, frame, timer and fraction,
// predicts each result as its request transfers and compares every field.
// ----------------------------------------------------------------------------

module kat_frame_checker
   import kat_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [FUNC_W-1:0]      req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [START_W-1:0]     csr_data,
   output int                          failures,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [NUMBER_W-1:0]   number;
      logic [FRACTION_W-1:0] fraction;
   } frame_report_type;

   frame_report_type       due_reports[$];

   logic [IN_TIME_W-1:0]   durations [REL_FRAMES];
   logic [FRAME_W-1:0]     rel_frame;
   logic [IN_TIME_W:0]     timer;
   logic [FRACTION_W-1:0]  fraction;
   logic [START_W-1:0]     start_frame;
   logic [FRAME_W-1:0]     frame_span;

   initial failures = 0;

   // a stored zero lasts one tick
   function automatic logic [IN_TIME_W:0] frame_ticks();
      return (durations[rel_frame] == '0) ? 17'd1 : {1'b0, durations[rel_frame]};
   endfunction

   task automatic advance_animation(func_type func, logic [REQ_DATA_W-1:0] data);
      logic [IN_TIME_W-1:0] elapsed;
      logic [FRAME_W-1:0]   slot;
      logic [IN_TIME_W-1:0] ticks;
      logic [IN_TIME_W:0]   dur;
      longint unsigned      quotient;
      frame_report_type     report;
      elapsed = data[15:0];
      slot    = data[21:16];
      ticks   = data[37:22];
      case (func)
         FUNC_TICK: begin
            timer = timer + {1'b0, elapsed};
            dur = frame_ticks();
            // skip whole frames, wrapping past the span
            while (timer > dur) begin
               timer = timer - dur;
               rel_frame = (rel_frame >= frame_span) ? '0 : rel_frame + 1'b1;
               dur = frame_ticks();
            end
            quotient = {timer, 16'h0000} / dur;
            fraction = (quotient > 64'd65536) ? 17'h10000 : quotient[FRACTION_W-1:0];
         end
         FUNC_WRITE: durations[slot] = ticks;
         FUNC_RESTART: begin
            rel_frame = '0;
            timer     = '0;
            fraction  = '0;
         end
         default: ;
      endcase
      report.number   = NUMBER_W'(start_frame) + NUMBER_W'(rel_frame);
      report.fraction = fraction;
      due_reports.insert(due_reports.size(), report);
   endtask

   task automatic check_report(logic [RSP_DATA_W-1:0] data);
      frame_report_type want;
      if (due_reports.size() == 0) begin
         failures = failures + 1;
         $display("%0t: result transfer with none due, frame %0d fraction %0d",
                  $realtime, data[10:0], data[27:11]);
         return;
      end
      want = due_reports.pop_front();
      if (data[10:0] !== want.number) begin
         failures = failures + 1;
         $display("%0t: frame_number expected %0d actual %0d",
                  $realtime, want.number, data[10:0]);
      end
      if (data[27:11] !== want.fraction) begin
         failures = failures + 1;
         $display("%0t: blend_fraction expected %0d actual %0d",
                  $realtime, want.fraction, data[27:11]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_reports.delete();
         rel_frame   = '0;
         timer       = '0;
         fraction    = '0;
         start_frame = '0;
         frame_span  = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_FRAME: start_frame = csr_data;
               CSR_FRAME_SPAN:  frame_span  = csr_data[FRAME_W-1:0];
               default: ;
            endcase
         end
         // results leave a register, so retire before adding this edge's request
         if (rsp_tvalid && rsp_tready)
            check_report(rsp_tdata);
         if (req_tvalid && req_tready)
            advance_animation(func_type'(req_tuser), req_tdata);
      end
      outstanding <= due_reports.size();
   end

endmodule

// ===== sim/keyframe_animation_timer_tb.sv =====
// ----------------------------------------------------------------------------
// keyframe_animation_timer_tb
// Drives the keyframe animation timer with a short directed run (zero and
// one-tick durations, full accumulator, frame beyond a lowered span, restart,
// no-operation) and then phases of random ticks, table writes and restarts
// under several start and span settings, with random stalls on both sides.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module keyframe_animation_timer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kat_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_500_000;
   localparam int          PHASE_ITEMS  = 220;

   // duration classes keep the number of skipped frames per tick small
   typedef enum {PACE_LONG, PACE_MEDIUM, PACE_SHORT} pace_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [FUNC_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [START_W-1:0]     csr_data;
   logic                   steady;
   int                     failures;
   int                     outstanding;
   int unsigned            cycle_count = 0;

   keyframe_animation_timer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   kat_frame_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 29);
   end

   function automatic logic [IN_TIME_W-1:0] pick_ticks(pace_type pace);
      case (pace)
         PACE_LONG:   return IN_TIME_W'($urandom_range(4096, 65535));
         PACE_MEDIUM: return IN_TIME_W'($urandom_range(256, 4095));
         default:     return IN_TIME_W'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic logic [IN_TIME_W-1:0] pick_elapsed(pace_type pace);
      case (pace)
         PACE_LONG:   return IN_TIME_W'($urandom_range(0, 65535));
         PACE_MEDIUM: return IN_TIME_W'($urandom_range(0, 8191));
         default:     return IN_TIME_W'($urandom_range(0, 63));
      endcase
   endfunction

   // entered and left at a falling edge; req_tvalid stays high for the next item
   task automatic send_item(func_type func, logic [IN_TIME_W-1:0] elapsed,
                            logic [FRAME_W-1:0] slot, logic [IN_TIME_W-1:0] ticks);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, ticks, slot, elapsed};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_tick(logic [IN_TIME_W-1:0] elapsed);
      send_item(FUNC_TICK, elapsed, FRAME_W'($urandom), IN_TIME_W'($urandom));
   endtask

   task automatic send_write(logic [FRAME_W-1:0] slot, logic [IN_TIME_W-1:0] ticks);
      send_item(FUNC_WRITE, IN_TIME_W'($urandom), slot, ticks);
   endtask

   task automatic send_restart();
      send_item(FUNC_RESTART, IN_TIME_W'($urandom), FRAME_W'($urandom),
                IN_TIME_W'($urandom));
   endtask

   // hold the sender until every result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [START_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(logic [START_W-1:0] start, logic [FRAME_W-1:0] span);
      logic [START_W-1:0] span_word;
      span_word = {4'($urandom), span};
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_START_FRAME, start);
         write_csr(CSR_FRAME_SPAN, span_word);
      end else begin
         write_csr(CSR_FRAME_SPAN, span_word);
         write_csr(CSR_START_FRAME, start);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic load_durations(pace_type pace);
      for (int slot = 0; slot < REL_FRAMES; slot++)
         send_write(FRAME_W'(slot), pick_ticks(pace));
   endtask

   task automatic run_phase(pace_type pace, logic [START_W-1:0] start,
                            logic [FRAME_W-1:0] span);
      int pick;
      drain();
      configure(start, span);
      // restart first so a leftover timer never meets a table of short frames
      send_restart();
      load_durations(pace);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 72)
            send_tick(pick_elapsed(pace));
         else if (pick < 84)
            send_write(FRAME_W'($urandom), pick_ticks(pace));
         else if (pick < 90)
            send_restart();
         else
            send_item(FUNC_NOP, IN_TIME_W'($urandom), FRAME_W'($urandom),
                      IN_TIME_W'($urandom));
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_NOP;
      csr_valid  = 1'b0;
      csr_index  = CSR_START_FRAME;
      csr_data   = '0;
      steady     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      configure(10'd1023, 6'd63);
      load_durations(PACE_LONG);

      // zero and one-tick frames at the start of the table
      send_write(6'd0, 16'd0);
      send_write(6'd1, 16'd1);
      send_restart();
      send_tick(16'd0);
      send_tick(16'd1);
      send_tick(16'd1);
      send_tick(16'd2);
      send_item(FUNC_NOP, 16'hFFFF, 6'h3F, 16'hFFFF);
      send_write(6'd0, 16'hFFFF);
      send_write(6'd1, 16'd40000);
      // lower the span below the current frame: next step wraps to zero
      drain();
      configure(10'd0, 6'd1);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      send_write(6'd63, 16'hFFFF);
      send_restart();

      run_phase(PACE_LONG, 10'd1023, 6'd63);
      run_phase(PACE_SHORT, 10'd0, 6'd0);
      steady = 1'b1;
      run_phase(PACE_MEDIUM, START_W'($urandom), FRAME_W'($urandom));
      steady = 1'b0;
      run_phase(PACE_LONG, START_W'($urandom), 6'd1);
      run_phase(PACE_SHORT, START_W'($urandom), FRAME_W'($urandom));
      run_phase(PACE_MEDIUM, 10'd1023, 6'd63);

      drain();
      repeat (100) @(negedge clock);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
